### rtl/spimf_pkg.sv
// Shared constants for the four-mode SPI master.
// Word sizes, item kind codes and configuration register indexes.
// No dependencies.
package spimf_pkg;

  localparam int MAX_WORD_BITS = 16;
  localparam int WORD_W        = 16;
  localparam int NARROW_LEN    = 8;
  localparam int WIDE_LEN      = (MAX_WORD_BITS < 16) ? MAX_WORD_BITS : 16;
  localparam int BITS_W        = $clog2(MAX_WORD_BITS + 1);

  typedef enum logic {
    KIND_OFFER = 1'b0,
    KIND_TICK  = 1'b1
  } item_kind_t;

  typedef enum logic {
    CFG_SPI_MODE   = 1'b0,
    CFG_WIDE_WORDS = 1'b1
  } cfg_index_t;

  typedef logic [MAX_WORD_BITS-1:0] shift_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [BITS_W-1:0]        bit_count_t;

endpackage

### rtl/spi_master_four_mode.sv
// SPI master, SPI modes 0 to 3 (CPOL/CPHA), 8/16-bit words, MSB first.
// Bus state update and registered result stage. Uses spimf_pkg.
//
//   channel | signals                                           | direction
//   --------+---------------------------------------------------+----------
//   in      | in_valid, in_stall, kind/tx_word/frame_end/miso    | to block
//   out     | out_valid, out_stall, pin levels, rx_word, flags   | from block
//   cfg     | cfg_wr_en, cfg_index, cfg_data                     | to block
//
// One transaction per clock while in_stall is low: the bus state is updated at the
// accepting edge and the result is in the output register the cycle after.
// in_stall follows out_stall only while a result is held in the output register.
// Sync reset (rst_n low): select state high, SCK state low, mode 0, 8-bit words.
module spi_master_four_mode
  import spimf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_tx_word,
  input  logic        in_frame_end,
  input  logic        in_miso_level,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sck_level,
  output logic        out_mosi_level,
  output logic        out_select_n,
  output logic [15:0] out_rx_word,
  output logic        out_word_done,
  output logic        out_busy_res,
  output logic        out_rejected,

  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic [1:0] spi_mode_r;
  logic       wide_words_r;

  shift_t     tx_shift_r,    tx_shift_nxt;
  word_t      rx_shift_r,    rx_shift_nxt;
  bit_count_t bits_left_r,   bits_left_nxt;
  logic       second_half_r, second_half_nxt;
  logic       active_r,      active_nxt;
  logic       end_pending_r, end_pending_nxt;
  logic       clock_pin_r,   clock_pin_nxt;
  logic       data_pin_r,    data_pin_nxt;
  logic       select_pin_r,  select_pin_nxt;

  logic       out_valid_r;
  word_t      rx_word_r,     rx_word_nxt;
  logic       word_done_r,   word_done_nxt;
  logic       rejected_r,    rejected_nxt;

  logic       accept;
  logic       cpol, cpha;
  shift_t     narrow_load, wide_load, tx_after;
  bit_count_t bits_dec;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cpol     = spi_mode_r[1];
  assign cpha     = spi_mode_r[0];

  // word sits left-aligned in the shifter
  assign narrow_load = MAX_WORD_BITS'(in_tx_word[NARROW_LEN-1:0])
                       << (MAX_WORD_BITS - NARROW_LEN);
  assign wide_load   = MAX_WORD_BITS'(in_tx_word[WIDE_LEN-1:0])
                       << (MAX_WORD_BITS - WIDE_LEN);
  assign tx_after    = tx_shift_r << 1;
  assign bits_dec    = (bits_left_r != '0) ? bits_left_r - 1'b1 : bits_left_r;

  always_comb begin
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    bits_left_nxt   = bits_left_r;
    second_half_nxt = second_half_r;
    active_nxt      = active_r;
    end_pending_nxt = end_pending_r;
    clock_pin_nxt   = clock_pin_r;
    data_pin_nxt    = data_pin_r;
    select_pin_nxt  = select_pin_r;
    rx_word_nxt     = '0;
    word_done_nxt   = 1'b0;
    rejected_nxt    = 1'b0;

    if (accept) begin
      if (item_kind_t'(in_kind) == KIND_OFFER) begin
        if (active_r) begin
          rejected_nxt = 1'b1;
        end else begin
          tx_shift_nxt    = wide_words_r ? wide_load : narrow_load;
          rx_shift_nxt    = '0;
          bits_left_nxt   = wide_words_r ? BITS_W'(WIDE_LEN) : BITS_W'(NARROW_LEN);
          second_half_nxt = 1'b0;
          active_nxt      = 1'b1;
          end_pending_nxt = in_frame_end;
          select_pin_nxt  = 1'b0;
          clock_pin_nxt   = cpol;
          if (!cpha) begin
            data_pin_nxt = wide_words_r ? wide_load[MAX_WORD_BITS-1]
                                        : narrow_load[MAX_WORD_BITS-1];
          end
        end
      end else if (!active_r) begin
        clock_pin_nxt = cpol;
      end else if (!second_half_r) begin
        // leading edge
        clock_pin_nxt = ~cpol;
        if (!cpha) begin
          rx_shift_nxt = {rx_shift_r[WORD_W-2:0], in_miso_level};
        end else begin
          data_pin_nxt = tx_shift_r[MAX_WORD_BITS-1];
          tx_shift_nxt = tx_after;
        end
        second_half_nxt = 1'b1;
      end else begin
        // trailing edge
        clock_pin_nxt = cpol;
        if (cpha) begin
          rx_shift_nxt = {rx_shift_r[WORD_W-2:0], in_miso_level};
        end else begin
          tx_shift_nxt = tx_after;
        end
        second_half_nxt = 1'b0;
        bits_left_nxt   = bits_dec;
        if (bits_dec == '0) begin
          word_done_nxt   = 1'b1;
          rx_word_nxt     = cpha ? {rx_shift_r[WORD_W-2:0], in_miso_level} : rx_shift_r;
          active_nxt      = 1'b0;
          end_pending_nxt = 1'b0;
          if (end_pending_r) begin
            select_pin_nxt = 1'b1;
          end
        end else if (!cpha) begin
          data_pin_nxt = tx_after[MAX_WORD_BITS-1];
        end
      end
    end else if (cfg_wr_en && cfg_index_t'(cfg_index) == CFG_SPI_MODE && !active_r) begin
      // idle clock follows a new polarity at once
      clock_pin_nxt = cfg_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spi_mode_r   <= 2'b00;
      wide_words_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SPI_MODE:   spi_mode_r   <= cfg_data;
        CFG_WIDE_WORDS: wide_words_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r    <= '0;
      rx_shift_r    <= '0;
      bits_left_r   <= '0;
      second_half_r <= 1'b0;
      active_r      <= 1'b0;
      end_pending_r <= 1'b0;
      clock_pin_r   <= 1'b0;
      data_pin_r    <= 1'b0;
      select_pin_r  <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      tx_shift_r    <= tx_shift_nxt;
      rx_shift_r    <= rx_shift_nxt;
      bits_left_r   <= bits_left_nxt;
      second_half_r <= second_half_nxt;
      active_r      <= active_nxt;
      end_pending_r <= end_pending_nxt;
      clock_pin_r   <= clock_pin_nxt;
      data_pin_r    <= data_pin_nxt;
      select_pin_r  <= select_pin_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  logic sck_res_r, mosi_res_r, sel_res_r, busy_res_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      sck_res_r   <= clock_pin_nxt;
      mosi_res_r  <= data_pin_nxt;
      sel_res_r   <= select_pin_nxt;
      busy_res_r  <= active_nxt;
      rx_word_r   <= rx_word_nxt;
      word_done_r <= word_done_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sck_level  = sck_res_r;
  assign out_mosi_level = mosi_res_r;
  assign out_select_n   = sel_res_r;
  assign out_rx_word    = rx_word_r;
  assign out_word_done  = word_done_r;
  assign out_busy_res   = busy_res_r;
  assign out_rejected   = rejected_r;

endmodule
